// ----- rtl/core/qard_pkg.sv -----
// ----------------------------------------------------------------------------
// Quad audio resample and decimate: shared types and constants
// Result word layout, the kind codes, the sideband that travels beside the
// interpolation lanes, and the fixed sizes of the lanes and the result queue.
// ----------------------------------------------------------------------------
package qard_pkg;

	// Two slots of two channels each: slot 0 left, slot 0 right,
	// slot 1 left, slot 1 right.
	localparam int LANES = 4;

	// Registers between the lane operand stage (s1) and the lane result (s6),
	// one for each of the lane stages s2 through s6.
	localparam int SIDE_DLY = 5;

	// Result queue depth; a power of two so the pointers wrap by themselves.
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Most results that one frame can cause.
	localparam int MAX_RESULTS = 3;

	// Haptic scaling: divide by 2**12, then clamp to a signed byte.
	localparam int HAP_SHIFT = 12;
	localparam int HAP_MIN   = -128;
	localparam int HAP_MAX   = 127;

	typedef enum logic {
		KIND_SPEAKER = 1'b0,
		KIND_HAPTIC  = 1'b1
	} qard_kind_t;

	typedef struct packed {
		qard_kind_t         kind;
		logic signed [15:0] value_a;
		logic signed [15:0] value_b;
		logic [8:0]         position;
		logic               block_end;
	} qard_word_t;

	typedef struct packed {
		logic               spk0_vld;
		logic               spk1_vld;
		logic               hap_vld;
		logic               blk_end;
		logic [8:0]         pos0;
		logic [8:0]         pos1;
		logic [8:0]         hap_pos;
		logic signed [15:0] hap_a;
		logic signed [15:0] hap_b;
	} qard_side_t;

endpackage

// ----- rtl/core/qard_ctrl.sv -----
// ----------------------------------------------------------------------------
// Frame control
// Tracks the frame position in the block and the next speaker output, picks
// the operands of both interpolation slots and runs the haptic accumulators.
// ----------------------------------------------------------------------------
module qard_ctrl import qard_pkg::*; #(
	parameter int BLOCK_FRAMES   = 512,
	parameter int SPEAKER_FRAMES = 480,
	parameter int HAPTIC_GROUP   = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  logic signed [15:0]                      spk_l,
	input  logic signed [15:0]                      spk_r,
	input  logic signed [15:0]                      hap_l,
	input  logic signed [15:0]                      hap_r,
	output logic [1:0]                              rsv,
	output logic signed [15:0]                      first_s1  [LANES],
	output logic signed [15:0]                      second_s1 [LANES],
	output logic [$clog2(SPEAKER_FRAMES-1)-1:0]     frac_s1   [LANES],
	output qard_side_t                              side_s1
);

	localparam int D    = SPEAKER_FRAMES - 1;
	localparam int N    = BLOCK_FRAMES - 1;
	localparam int FW   = $clog2(BLOCK_FRAMES);
	localparam int IW   = $clog2(SPEAKER_FRAMES + 1);
	localparam int FRW  = $clog2(D);
	localparam int HW   = 16 + $clog2(HAPTIC_GROUP);
	localparam int GCW  = $clog2(HAPTIC_GROUP);
	localparam int NQ   = N / D;
	localparam int NR   = N % D;
	localparam int N2Q  = (2 * N) / D;
	localparam int N2R  = (2 * N) % D;

	localparam logic signed [HW-1:0] HMIN = HW'(HAP_MIN);
	localparam logic signed [HW-1:0] HMAX = HW'(HAP_MAX);

	logic [FW-1:0]         frame_q;
	logic signed [15:0]    prev_l_q, prev_r_q;
	logic [IW-1:0]         idx_q;
	logic [FW-1:0]         b0_q, b1_q;
	logic [FRW-1:0]        fr0_q, fr1_q;
	logic signed [HW-1:0]  hsa_q, hsb_q;
	logic [GCW-1:0]        gcnt_q;
	logic [8:0]            hidx_q;

	logic [FW:0]           sec0, sec1;
	logic                  v0, v1, hv, blk_last;
	logic signed [15:0]    f0l, f0r, s0l, s0r, f1l, f1r, s1l, s1r;
	logic [FW-1:0]         nb0, nb1;
	logic [FRW:0]          nf0, nf1;
	logic signed [HW-1:0]  sa, sb, qa, qb;

	always_comb begin
		sec0 = ({1'b0, b0_q} + 1'b1 < (FW+1)'(BLOCK_FRAMES)) ?
			{1'b0, b0_q} + 1'b1 : (FW+1)'(BLOCK_FRAMES - 1);
		sec1 = ({1'b0, b1_q} + 1'b1 < (FW+1)'(BLOCK_FRAMES)) ?
			{1'b0, b1_q} + 1'b1 : (FW+1)'(BLOCK_FRAMES - 1);

		// An output is due once its second source frame is the current one or older.
		v0 = accept && (idx_q < IW'(SPEAKER_FRAMES)) && (sec0 <= {1'b0, frame_q});
		v1 = v0 && (({1'b0, idx_q} + 1'b1) < (IW+1)'(SPEAKER_FRAMES))
			&& (sec1 <= {1'b0, frame_q});

		f0l = (b0_q >= frame_q) ? spk_l : prev_l_q;
		f0r = (b0_q >= frame_q) ? spk_r : prev_r_q;
		s0l = (sec0 >= {1'b0, frame_q}) ? spk_l : prev_l_q;
		s0r = (sec0 >= {1'b0, frame_q}) ? spk_r : prev_r_q;
		f1l = (b1_q >= frame_q) ? spk_l : prev_l_q;
		f1r = (b1_q >= frame_q) ? spk_r : prev_r_q;
		s1l = (sec1 >= {1'b0, frame_q}) ? spk_l : prev_l_q;
		s1r = (sec1 >= {1'b0, frame_q}) ? spk_r : prev_r_q;

		// Position two outputs ahead, one add and compare per slot.
		nb0 = b0_q + FW'(N2Q);
		nf0 = {1'b0, fr0_q} + (FRW+1)'(N2R);
		if (nf0 >= (FRW+1)'(D)) begin
			nf0 = nf0 - (FRW+1)'(D);
			nb0 = nb0 + 1'b1;
		end
		nb1 = b1_q + FW'(N2Q);
		nf1 = {1'b0, fr1_q} + (FRW+1)'(N2R);
		if (nf1 >= (FRW+1)'(D)) begin
			nf1 = nf1 - (FRW+1)'(D);
			nb1 = nb1 + 1'b1;
		end

		// Haptic sums, then divide by 4096 rounding toward zero and clamp.
		sa = hsa_q + HW'(hap_l);
		sb = hsb_q + HW'(hap_r);
		hv = accept && (gcnt_q == GCW'(HAPTIC_GROUP - 1));
		qa = sa >>> HAP_SHIFT;
		qb = sb >>> HAP_SHIFT;
		if (sa[HW-1] && (|sa[HAP_SHIFT-1:0])) begin
			qa = qa + 1'b1;
		end
		if (sb[HW-1] && (|sb[HAP_SHIFT-1:0])) begin
			qb = qb + 1'b1;
		end
		if (qa < HMIN) begin
			qa = HMIN;
		end
		if (qa > HMAX) begin
			qa = HMAX;
		end
		if (qb < HMIN) begin
			qb = HMIN;
		end
		if (qb > HMAX) begin
			qb = HMAX;
		end

		blk_last = (frame_q == FW'(BLOCK_FRAMES - 1));
		rsv = {1'b0, v0} + {1'b0, v1} + {1'b0, hv};
	end

	// Lane operands; payload, no reset.
	always_ff @(posedge clk) begin
		first_s1[0]  <= f0l;
		first_s1[1]  <= f0r;
		first_s1[2]  <= f1l;
		first_s1[3]  <= f1r;
		second_s1[0] <= s0l;
		second_s1[1] <= s0r;
		second_s1[2] <= s1l;
		second_s1[3] <= s1r;
		frac_s1[0]   <= fr0_q;
		frac_s1[1]   <= fr0_q;
		frac_s1[2]   <= fr1_q;
		frac_s1[3]   <= fr1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.spk0_vld <= v0;
			side_s1.spk1_vld <= v1;
			side_s1.hap_vld  <= hv;
			side_s1.blk_end  <= accept && blk_last;
			side_s1.pos0     <= 9'(idx_q);
			side_s1.pos1     <= 9'(idx_q + IW'(1));
			side_s1.hap_pos  <= hidx_q;
			side_s1.hap_a    <= 16'(qa);
			side_s1.hap_b    <= 16'(qb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
			idx_q    <= '0;
			b0_q     <= '0;
			fr0_q    <= '0;
			b1_q     <= FW'(NQ);
			fr1_q    <= FRW'(NR);
			hsa_q    <= '0;
			hsb_q    <= '0;
			gcnt_q   <= '0;
			hidx_q   <= '0;
		end else if (accept) begin
			prev_l_q <= spk_l;
			prev_r_q <= spk_r;
			if (blk_last) begin
				frame_q <= '0;
				idx_q   <= '0;
				b0_q    <= '0;
				fr0_q   <= '0;
				b1_q    <= FW'(NQ);
				fr1_q   <= FRW'(NR);
				hsa_q   <= '0;
				hsb_q   <= '0;
				gcnt_q  <= '0;
				hidx_q  <= '0;
			end else begin
				frame_q <= frame_q + 1'b1;
				idx_q   <= idx_q + IW'({1'b0, v0} + {1'b0, v1});
				if (v1) begin
					b0_q  <= nb0;
					fr0_q <= FRW'(nf0);
					b1_q  <= nb1;
					fr1_q <= FRW'(nf1);
				end else if (v0) begin
					b0_q  <= b1_q;
					fr0_q <= fr1_q;
					b1_q  <= nb0;
					fr1_q <= FRW'(nf0);
				end
				if (hv) begin
					hsa_q  <= '0;
					hsb_q  <= '0;
					gcnt_q <= '0;
					hidx_q <= hidx_q + 1'b1;
				end else begin
					hsa_q  <= sa;
					hsb_q  <= sb;
					gcnt_q <= gcnt_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/qard_blend_lane.sv -----
// ----------------------------------------------------------------------------
// Interpolation lane
// Weights two samples by their fractional position and divides by the span
// through a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module qard_blend_lane import qard_pkg::*; #(
	parameter int SPEAKER_FRAMES = 480
) (
	input  logic                                clk,
	input  logic signed [15:0]                  first_s1,
	input  logic signed [15:0]                  second_s1,
	input  logic [$clog2(SPEAKER_FRAMES-1)-1:0] frac_s1,
	output logic signed [15:0]                  result_s6
);

	localparam int D   = SPEAKER_FRAMES - 1;
	localparam int FRW = $clog2(D);
	localparam int WW  = $clog2(D + 1);
	localparam int VW  = 16 + WW;
	localparam int MW  = VW - 1;
	localparam int QW  = 17;

	localparam logic [MW-1:0] RECIP = MW'((64'd1 << MW) / D);
	localparam logic [MW-1:0] DM    = MW'(D);

	logic [WW-1:0]        wfirst;
	logic signed [VW-1:0] p1_s2, p2_s2, vsum;
	logic [MW-1:0]        m_s3, m_s4, m_s5;
	logic                 neg_s3, neg_s4, neg_s5;
	logic [2*MW-1:0]      prod;
	logic [QW-1:0]        q0_s4, q0_s5, q;
	logic [MW-1:0]        qd_s5, rem;

	always_comb begin
		wfirst = WW'(D) - WW'(frac_s1);
		vsum   = p1_s2 + p2_s2;
		prod   = (2*MW)'(m_s3) * (2*MW)'(RECIP);
		// The reciprocal estimate is low by at most one.
		rem    = m_s5 - qd_s5;
		q      = (rem >= DM) ? q0_s5 + 1'b1 : q0_s5;
	end

	always_ff @(posedge clk) begin
		p1_s2     <= VW'(first_s1) * VW'(wfirst);
		p2_s2     <= VW'(second_s1) * VW'(frac_s1);
		neg_s3    <= vsum[VW-1];
		m_s3      <= MW'(vsum[VW-1] ? -vsum : vsum);
		q0_s4     <= QW'(prod >> MW);
		m_s4      <= m_s3;
		neg_s4    <= neg_s3;
		qd_s5     <= MW'(q0_s4) * DM;
		q0_s5     <= q0_s4;
		m_s5      <= m_s4;
		neg_s5    <= neg_s4;
		result_s6 <= 16'(neg_s5 ? -q : q);
	end

endmodule

// ----- rtl/core/qard_merge.sv -----
// ----------------------------------------------------------------------------
// Result merge
// Aligns the sideband with the lane results, writes up to three words a
// cycle into the result queue in order, and grants input space by credit.
// ----------------------------------------------------------------------------
module qard_merge import qard_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         rsv,
	input  qard_side_t         side_s1,
	input  logic signed [15:0] res_s6 [LANES],
	input  logic               out_ready,
	output logic               in_ready,
	output logic               out_valid,
	output qard_word_t         out_word
);

	qard_side_t        side_dly_q [SIDE_DLY];
	qard_side_t        side_s6;
	qard_word_t        fifo_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] cnt_q, used_q;
	qard_word_t        c0, c1, c2;
	logic [1:0]        o1, o2, npush;
	logic              pop;

	always_comb begin
		side_s6 = side_dly_q[SIDE_DLY-1];

		c0.kind      = KIND_SPEAKER;
		c0.value_a   = res_s6[0];
		c0.value_b   = res_s6[1];
		c0.position  = side_s6.pos0;
		c0.block_end = side_s6.blk_end && !side_s6.spk1_vld && !side_s6.hap_vld;

		c1.kind      = KIND_SPEAKER;
		c1.value_a   = res_s6[2];
		c1.value_b   = res_s6[3];
		c1.position  = side_s6.pos1;
		c1.block_end = side_s6.blk_end && !side_s6.hap_vld;

		c2.kind      = KIND_HAPTIC;
		c2.value_a   = side_s6.hap_a;
		c2.value_b   = side_s6.hap_b;
		c2.position  = side_s6.hap_pos;
		c2.block_end = side_s6.blk_end;

		o1    = {1'b0, side_s6.spk0_vld};
		o2    = o1 + {1'b0, side_s6.spk1_vld};
		npush = o2 + {1'b0, side_s6.hap_vld};

		out_valid = (cnt_q != '0);
		out_word  = fifo_q[rd_q];
		pop       = out_valid && out_ready;
		// Room for a frame's worth of results, counting those still in the lanes.
		in_ready  = (used_q <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIDE_DLY; i++) begin
				side_dly_q[i] <= '0;
			end
		end else begin
			side_dly_q[0] <= side_s1;
			for (int i = 1; i < SIDE_DLY; i++) begin
				side_dly_q[i] <= side_dly_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (side_s6.spk0_vld) begin
			fifo_q[wr_q] <= c0;
		end
		if (side_s6.spk1_vld) begin
			fifo_q[wr_q + FIFO_PW'(o1)] <= c1;
		end
		if (side_s6.hap_vld) begin
			fifo_q[wr_q + FIFO_PW'(o2)] <= c2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
			used_q <= '0;
		end else begin
			wr_q   <= wr_q + FIFO_PW'(npush);
			rd_q   <= rd_q + FIFO_PW'(pop);
			cnt_q  <= cnt_q + FIFO_CW'(npush) - FIFO_CW'(pop);
			used_q <= used_q + FIFO_CW'(accept ? rsv : 2'd0) - FIFO_CW'(pop);
		end
	end

endmodule

// ----- rtl/core/quad_audio_resample_and_decimate_unit.sv -----
// Path: a frame's results pass stages s1 through s6, then the result queue.
// Throughput: one frame per cycle while the 16-word result queue has room for
// three more words; the output drains one word per cycle while m_axis_tready is high,
// so words per frame set the long-run rate (one on average with the default sizes).
// Reset: arst_n clears the block position, accumulators, queue and pipeline valids.
// ----------------------------------------------------------------------------
// Quad audio resample and decimate unit
// Resamples the speaker pair of each block by linear interpolation and
// decimates the haptic pair by group sums, emitting tagged result words.
// ----------------------------------------------------------------------------
module quad_audio_resample_and_decimate_unit import qard_pkg::*; #(
	parameter int BLOCK_FRAMES   = 512,
	parameter int SPEAKER_FRAMES = 480,
	parameter int HAPTIC_GROUP   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// speaker_left_in [15:0], speaker_right_in [31:16],
	// haptic_left_in [47:32], haptic_right_in [63:48]
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// value_a [15:0], value_b [31:16], position [40:32], zero fill [47:41]
	output logic [47:0] m_axis_tdata,
	// kind: 0 resampled speaker pair, 1 decimated haptic pair
	output logic        m_axis_tuser,
	// block_end: set on the final result of a block
	output logic        m_axis_tlast
);

	localparam int FRW = $clog2(SPEAKER_FRAMES - 1);

	logic               accept;
	logic signed [15:0] speaker_left_in, speaker_right_in;
	logic signed [15:0] haptic_left_in, haptic_right_in;
	logic [1:0]         rsv;
	logic signed [15:0] first_s1  [LANES];
	logic signed [15:0] second_s1 [LANES];
	logic [FRW-1:0]     frac_s1   [LANES];
	logic signed [15:0] res_s6    [LANES];
	qard_side_t         side_s1;
	qard_word_t         out_word;

	// A word enters when the queue has reserved space for everything it can cause.
	assign accept           = s_axis_tvalid && s_axis_tready;
	assign speaker_left_in  = s_axis_tdata[15:0];
	assign speaker_right_in = s_axis_tdata[31:16];
	assign haptic_left_in   = s_axis_tdata[47:32];
	assign haptic_right_in  = s_axis_tdata[63:48];

	// Frame tracking, slot selection and haptic accumulation.
	qard_ctrl #(
		.BLOCK_FRAMES   (BLOCK_FRAMES),
		.SPEAKER_FRAMES (SPEAKER_FRAMES),
		.HAPTIC_GROUP   (HAPTIC_GROUP)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.spk_l     (speaker_left_in),
		.spk_r     (speaker_right_in),
		.hap_l     (haptic_left_in),
		.hap_r     (haptic_right_in),
		.rsv       (rsv),
		.first_s1  (first_s1),
		.second_s1 (second_s1),
		.frac_s1   (frac_s1),
		.side_s1   (side_s1)
	);

	// Four interpolation lanes: two output slots per frame, left and right each.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		qard_blend_lane #(
			.SPEAKER_FRAMES (SPEAKER_FRAMES)
		) u_lane (
			.clk       (clk),
			.first_s1  (first_s1[g]),
			.second_s1 (second_s1[g]),
			.frac_s1   (frac_s1[g]),
			.result_s6 (res_s6[g])
		);
	end

	// Orders the speaker and haptic results into the queue and drives the output.
	qard_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rsv       (rsv),
		.side_s1   (side_s1),
		.res_s6    (res_s6),
		.out_ready (m_axis_tready),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_word  (out_word)
	);

	assign m_axis_tdata = {7'd0, out_word.position, out_word.value_b, out_word.value_a};
	assign m_axis_tuser = out_word.kind;
	assign m_axis_tlast = out_word.block_end;

endmodule
